FILE: sv/scalar_kalman_filter_macros.svh
// Assertion helpers shared by the filter RTL.
`ifndef SCALAR_KALMAN_FILTER_MACROS_SVH
`define SCALAR_KALMAN_FILTER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SKF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define SKF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/skf_pkg.sv
`default_nettype none

package skf_pkg;

    // Field widths.
    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned EST_W    = 24;
    localparam int unsigned COV_W    = 32;
    localparam int unsigned GAIN_W   = 17;
    localparam int unsigned NOISE_W  = 24;
    localparam int unsigned A_W      = 16;

    // Shared multiplier: 18-bit signed times 33-bit signed.
    localparam int unsigned MUL_A_W = 18;
    localparam int unsigned MUL_B_W = 33;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

    // Configuration register indexes and reset values.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_Q = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_R = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_A = 2'd2;

    localparam logic [NOISE_W-1:0] Q_RESET = 24'd256;
    localparam logic [NOISE_W-1:0] R_RESET = 24'd10240;
    localparam logic [A_W-1:0]     A_RESET = 16'd256;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

    // Gain divider: one quotient bit per step.
    localparam int unsigned DIV_STEPS = GAIN_W;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Microprogram.
    localparam int unsigned PROG_LEN = 9;
    localparam int unsigned PC_W     = $clog2(PROG_LEN);
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t ST_DIV_LOOP = pc_t'(5);
    localparam pc_t ST_APPLY    = pc_t'(6);

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_AX,
        MUL_AP,
        MUL_KD,
        MUL_KP
    } mul_op_t;

    typedef enum logic [2:0] {
        WB_NONE,
        WB_XMID,
        WB_PMID,
        WB_DEN,
        WB_DIVINIT,
        WB_DIVSTEP,
        WB_XNEW,
        WB_PNEW
    } wb_op_t;

    typedef enum logic [1:0] {
        JMP_NONE,
        JMP_DEN_ZERO,
        JMP_DIV_MORE
    } jmp_t;

    typedef struct packed {
        mul_op_t mul;
        wb_op_t  wb;
        jmp_t    jmp;
        pc_t     target;
        logic    last;
    } ucode_t;

    // Control store. A conditional jump goes to target when its condition
    // holds, otherwise the step counter advances by one.
    function automatic ucode_t ucode_rom(input pc_t pc);
        ucode_t w;
        w = '{mul: MUL_NONE, wb: WB_NONE, jmp: JMP_NONE, target: '0, last: 1'b0};
        case (pc)
            pc_t'(0): w.mul = MUL_AX;
            pc_t'(1):
            begin
                w.wb  = WB_XMID;
                w.mul = MUL_AP;
            end
            pc_t'(2): w.wb = WB_PMID;
            pc_t'(3): w.wb = WB_DEN;
            pc_t'(4):
            begin
                w.wb     = WB_DIVINIT;
                w.jmp    = JMP_DEN_ZERO;
                w.target = ST_APPLY;
            end
            pc_t'(5):
            begin
                w.wb     = WB_DIVSTEP;
                w.jmp    = JMP_DIV_MORE;
                w.target = ST_DIV_LOOP;
            end
            pc_t'(6): w.mul = MUL_KD;
            pc_t'(7):
            begin
                w.wb  = WB_XNEW;
                w.mul = MUL_KP;
            end
            pc_t'(8):
            begin
                w.wb   = WB_PNEW;
                w.last = 1'b1;
            end
            default: w.last = 1'b1;
        endcase
        return w;
    endfunction

    // Saturate a signed value to the 24-bit estimate range.
    function automatic logic [EST_W-1:0] sat_est(input logic [43:0] v);
        logic all_one;
        logic all_zero;
        all_one  = &v[43:EST_W-1];
        all_zero = ~|v[43:EST_W-1];
        if (all_one || all_zero)
        begin
            return v[EST_W-1:0];
        end
        return v[43] ? {1'b1, {(EST_W-1){1'b0}}} : {1'b0, {(EST_W-1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

FILE: sv/scalar_kalman_filter.sv
`default_nettype none
//  Channel   Handshake             Payload                      Direction
//  in        in_valid / in_stall   sample (s16)                 into block
//  out       out_valid / out_stall estimate (s24), gain (u17)   out of block
//  cfg       cfg_valid / cfg_ready cfg_index (2), cfg_data (24) into block
//
//  An item runs from acceptance to the result register through eight
//  microcode steps plus the gain division step, run once for each of the 17
//  quotient bits. If P+R is zero the division is skipped.
//  rst_n (asynchronous) restores Q, R and A and clears x, P and all control state.
//  in_stall stays high while an item is worked, so items do not overlap;
//  a result held by out_stall only holds the last step of the following item.

`include "scalar_kalman_filter_macros.svh"

module scalar_kalman_filter
    import skf_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,

    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [SAMPLE_W-1:0]  sample,

    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [EST_W-1:0]     estimate,
    output logic [GAIN_W-1:0]           gain,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [NOISE_W-1:0]          cfg_data
);

    // Configuration registers.
    logic [NOISE_W-1:0] q_reg;
    logic [NOISE_W-1:0] r_reg;
    logic [A_W-1:0]     a_reg;

    // Filter state: estimate x (signed Q16.8) and covariance P (Q24.8).
    logic [EST_W-1:0] x_reg;
    logic [COV_W-1:0] p_reg;

    // Sequencer.
    logic busy_reg;
    pc_t  pc_reg;
    pc_t  pc_next;

    // Working registers of the datapath.
    logic [SAMPLE_W-1:0]         z_reg;
    logic [EST_W-1:0]            xmid_reg;
    logic [COV_W-1:0]            pmid_reg;
    logic [EST_W:0]              diff_reg;
    logic [COV_W:0]              den_reg;
    logic [COV_W:0]              rem_reg;
    logic [GAIN_W-1:0]           nlo_reg;
    logic [GAIN_W-1:0]           k_reg;
    logic [DIV_CNT_W-1:0]        cnt_reg;
    logic signed [PROD_W-1:0]    prod_reg;

    // Result register.
    logic              out_valid_reg;
    logic [EST_W-1:0]  estimate_reg;
    logic [GAIN_W-1:0] gain_reg;

    ucode_t uw;
    logic   hold;
    logic   run;
    logic   in_accept;
    logic   jump_taken;

    logic signed [MUL_A_W-1:0] op_a;
    logic signed [MUL_B_W-1:0] op_b;
    logic signed [PROD_W-1:0]  prod_next;

    logic signed [PROD_W-1:0] bias8;
    logic signed [PROD_W-1:0] bias16;
    logic signed [PROD_W-1:0] r8_sum;
    logic signed [PROD_W-1:0] r16_sum;
    logic [PROD_W-9:0]        r8;
    logic [PROD_W-17:0]       r16;

    logic [EST_W-1:0]  xmid_next;
    logic [40:0]       pm_sum;
    logic [COV_W-1:0]  pmid_next;
    logic [COV_W:0]    den_next;
    logic [EST_W:0]    diff_next;
    logic [48:0]       num;
    logic [COV_W+1:0]  trial;
    logic [COV_W+1:0]  trial_sub;
    logic              q_bit;
    logic [COV_W:0]    rem_next;
    logic [35:0]       xnew_sum;
    logic [EST_W-1:0]  x_next;
    logic [COV_W-1:0]  p_next;

    // The current control word, decoded straight from the step counter.
    assign uw = ucode_rom(pc_reg);

    // The final step publishes a result, so it waits while the previous one
    // is still held in the output register.
    assign hold      = uw.last && out_valid_reg && out_stall;
    assign run       = busy_reg && !hold;
    assign in_stall  = busy_reg;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign out_valid = out_valid_reg;
    assign estimate  = estimate_reg;
    assign gain      = gain_reg;

    // Operand selection for the single shared multiplier.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (uw.mul)
            MUL_AX:
            begin
                op_a = {2'b00, a_reg};
                op_b = {{(MUL_B_W-EST_W){x_reg[EST_W-1]}}, x_reg};
            end
            MUL_AP:
            begin
                op_a = {2'b00, a_reg};
                op_b = {1'b0, p_reg};
            end
            MUL_KD:
            begin
                op_a = {1'b0, k_reg};
                op_b = {{(MUL_B_W-EST_W-1){diff_reg[EST_W]}}, diff_reg};
            end
            MUL_KP:
            begin
                op_a = {1'b0, GAIN_ONE - k_reg};
                op_b = {1'b0, pmid_reg};
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign prod_next = op_a * op_b;

    // Round to nearest with ties away from zero: adding half minus one for
    // negative values and then shifting arithmetically gives the same result
    // as rounding the magnitude.
    assign bias8   = prod_reg[PROD_W-1] ? PROD_W'(127) : PROD_W'(128);
    assign bias16  = prod_reg[PROD_W-1] ? PROD_W'(32767) : PROD_W'(32768);
    assign r8_sum  = prod_reg + bias8;
    assign r16_sum = prod_reg + bias16;
    assign r8      = r8_sum[PROD_W-1:8];
    assign r16     = r16_sum[PROD_W-1:16];

    // Predict.
    assign xmid_next = sat_est({{(44-(PROD_W-8)){r8[PROD_W-9]}}, r8});
    assign pm_sum    = {1'b0, r8[39:0]} + 41'(q_reg);
    assign pmid_next = (|pm_sum[40:COV_W]) ? {COV_W{1'b1}} : pm_sum[COV_W-1:0];

    // Gain denominator and innovation.
    assign den_next  = {1'b0, pmid_reg} + (COV_W+1)'(r_reg);
    assign diff_next = {z_reg[SAMPLE_W-1], z_reg, 8'd0} - {xmid_reg[EST_W-1], xmid_reg};

    // Rounded dividend P*2^16 + floor(den/2). The quotient never exceeds
    // 2^16, so its top 32 bits already sit below the divisor.
    assign num = {1'b0, pmid_reg, 16'd0} + 49'(den_reg[COV_W:1]);

    // One restoring division step.
    assign trial     = {rem_reg, nlo_reg[GAIN_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign q_bit     = (trial >= {1'b0, den_reg});
    assign rem_next  = q_bit ? trial_sub[COV_W:0] : trial[COV_W:0];

    // Update.
    assign xnew_sum = {{12{xmid_reg[EST_W-1]}}, xmid_reg} + {r16[PROD_W-17], r16};
    assign x_next   = sat_est({{8{xnew_sum[35]}}, xnew_sum});
    assign p_next   = r16[COV_W-1:0];

    always_comb
    begin
        case (uw.jmp)
            JMP_DEN_ZERO: jump_taken = (den_reg == '0);
            JMP_DIV_MORE: jump_taken = (cnt_reg != DIV_CNT_W'(1));
            default:      jump_taken = 1'b0;
        endcase
    end

    assign pc_next = jump_taken ? uw.target : pc_reg + pc_t'(1);

    // Control state, configuration and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            q_reg         <= Q_RESET;
            r_reg         <= R_RESET;
            a_reg         <= A_RESET;
            x_reg         <= '0;
            p_reg         <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_IDX_Q: q_reg <= cfg_data;
                    CFG_IDX_R: r_reg <= cfg_data;
                    CFG_IDX_A: a_reg <= cfg_data[A_W-1:0];
                    default:   ;
                endcase
            end

            // A new result may replace one that leaves in the same cycle.
            if (run && uw.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (in_accept)
            begin
                busy_reg <= 1'b1;
                pc_reg   <= '0;
            end
            else if (run)
            begin
                pc_reg <= pc_next;
                if (uw.wb == WB_DIVINIT)
                begin
                    cnt_reg <= DIV_CNT_W'(DIV_STEPS);
                end
                if (uw.wb == WB_DIVSTEP)
                begin
                    cnt_reg <= cnt_reg - DIV_CNT_W'(1);
                end
                if (uw.wb == WB_XNEW)
                begin
                    x_reg <= x_next;
                end
                if (uw.wb == WB_PNEW)
                begin
                    p_reg <= p_next;
                end
                if (uw.last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath working registers and the result payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            z_reg <= sample;
        end
        if (run)
        begin
            if (uw.mul != MUL_NONE)
            begin
                prod_reg <= prod_next;
            end
            case (uw.wb)
                WB_XMID: xmid_reg <= xmid_next;
                WB_PMID: pmid_reg <= pmid_next;
                WB_DEN:
                begin
                    den_reg  <= den_next;
                    diff_reg <= diff_next;
                end
                WB_DIVINIT:
                begin
                    rem_reg <= {1'b0, num[48:GAIN_W]};
                    nlo_reg <= num[GAIN_W-1:0];
                    k_reg   <= '0;
                end
                WB_DIVSTEP:
                begin
                    rem_reg <= rem_next;
                    nlo_reg <= {nlo_reg[GAIN_W-2:0], 1'b0};
                    k_reg   <= {k_reg[GAIN_W-2:0], q_bit};
                end
                default: ;
            endcase
            if (uw.last)
            begin
                estimate_reg <= x_reg;
                gain_reg     <= k_reg;
            end
        end
    end

    // The gain is a fraction of one at most.
    `SKF_ASSERT_IMPLY(a_gain_bound, clk, rst_n, out_valid,
        gain <= GAIN_ONE, "gain above one")

    // An accepted sample starts the program from its first step.
    `SKF_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_valid && !in_stall,
        busy_reg && pc_reg == '0, "program did not start at step zero")

    // The division loop never runs more passes than there are quotient bits.
    `SKF_ASSERT_IMPLY(a_div_count, clk, rst_n, busy_reg,
        cnt_reg <= DIV_CNT_W'(DIV_STEPS), "divider count out of range")

    // The corrected covariance never exceeds the predicted one.
    `SKF_ASSERT_NEXT(a_cov_shrinks, clk, rst_n, run && uw.wb == WB_PNEW,
        p_reg <= $past(pmid_reg), "covariance grew in the update")

endmodule

`default_nettype wire
